// ===== hdl/qvr_pkg.sv =====
// Package for the quaternion vector rotator.
// Holds the quaternion register type, configuration register codes and pipeline enables.
// No dependencies.
package qvr_pkg;

    localparam int QW = 16;
    localparam int NSTAGE = 5;

    typedef enum logic [1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic prod_en;
        logic mat_en;
        logic mul_en;
        logic acc_en;
        logic out_en;
    } t_pipe_ctl;

endpackage

// ===== hdl/qvr_vec_if.sv =====
// Input channel of the quaternion vector rotator: one 3-D vector per transfer.
// Standalone interface, no dependencies.
interface qvr_vec_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vec_x;
    logic signed [W-1:0] vec_y;
    logic signed [W-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== hdl/qvr_rot_if.sv =====
// Output channel of the quaternion vector rotator: one rotated vector and overflow flag.
// Standalone interface, no dependencies.
interface qvr_rot_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rot_x;
    logic signed [W-1:0] rot_y;
    logic signed [W-1:0] rot_z;
    logic                overflow;

    modport source (output valid, output rot_x, output rot_y, output rot_z, output overflow,
                    input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z, input overflow,
                    output ready);
endinterface

// ===== hdl/quaternion_vector_rotator_core.sv =====
// Quaternion vector rotator top level: config registers, pipeline control, three lanes.
// Depends on qvr_pkg, qvr_vec_if, qvr_rot_if, qvr_matrix, qvr_lane, qvr_merge.
//
// Rotates each input vector by the quaternion in registers quat_w/x/y/z (signed Q1.14 by
// default). Write a register through i_cfg_we/i_cfg_idx/i_cfg_data; index 0..3 selects
// w, x, y, z. The user must write registers only while no vector is in flight; unenforced.
// Input channel i_vec carries vec_x/y/z; output channel o_rot carries rot_x/y/z and an
// overflow flag set when any component saturated. A transfer happens when valid and
// ready are both high.
// Pipeline: five registered stages: quaternion products, matrix, lane multiply,
// lane sum and round, output register.
// Throughput: one vector per cycle. Each stage has its own valid bit, so the pipeline
// keeps accepting while bubbles remain ahead of a stalled output.
// When o_rot.ready stays low, the stages fill up and i_vec.ready drops once all five
// hold a vector; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the identity
// quaternion (w = 1.0, x = y = z = 0).
module quaternion_vector_rotator_core #(
    parameter int VECTOR_WIDTH   = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [qvr_pkg::QW-1:0]      i_cfg_data,
    qvr_vec_if.sink                     i_vec,
    qvr_rot_if.source                   o_rot
);
    import qvr_pkg::*;

    localparam int VW = VECTOR_WIDTH;
    localparam int QF = QUAT_FRAC_BITS;
    localparam int MW = (2 * QF + 2 > 2 * QW + 2) ? 2 * QF + 2 : 2 * QW + 2;

    t_quat               r_quat;
    logic [NSTAGE-1:0]   r_vld;
    logic [NSTAGE-1:0]   n_vld;
    logic [NSTAGE-1:0]   free;
    logic [NSTAGE-1:0]   drain;
    logic [NSTAGE-1:0]   adv;
    t_pipe_ctl           ctl;

    logic signed [VW-1:0] vec_in  [3];
    logic signed [VW-1:0] vec_mat [3];
    logic signed [MW-1:0] mat     [3][3];
    logic signed [VW-1:0] res     [3];
    logic [2:0]           ovf;
    logic signed [VW-1:0] rot     [3];
    logic                 rot_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= QW'(1) << QF;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_QUAT_W: r_quat.w <= i_cfg_data;
                REG_QUAT_X: r_quat.x <= i_cfg_data;
                REG_QUAT_Y: r_quat.y <= i_cfg_data;
                REG_QUAT_Z: r_quat.z <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        drain[NSTAGE-1] = o_rot.ready;
        free[NSTAGE-1]  = !r_vld[NSTAGE-1] || drain[NSTAGE-1];
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            drain[i] = free[i+1];
            free[i]  = !r_vld[i] || drain[i];
        end
        adv[0] = i_vec.valid && free[0];
        for (int i = 1; i < NSTAGE; i++) begin
            adv[i] = r_vld[i-1] && free[i];
        end
        for (int i = 0; i < NSTAGE; i++) begin
            n_vld[i] = adv[i] || (r_vld[i] && !drain[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign ctl.prod_en = adv[0];
    assign ctl.mat_en  = adv[1];
    assign ctl.mul_en  = adv[2];
    assign ctl.acc_en  = adv[3];
    assign ctl.out_en  = adv[4];

    assign vec_in[0] = i_vec.vec_x;
    assign vec_in[1] = i_vec.vec_y;
    assign vec_in[2] = i_vec.vec_z;
    assign i_vec.ready = free[0];

    qvr_matrix #(.VW(VW), .QF(QF), .MW(MW)) u_matrix (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_quat (r_quat),
        .i_vec  (vec_in),
        .o_vec  (vec_mat),
        .o_mat  (mat)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        qvr_lane #(.VW(VW), .QF(QF), .MW(MW)) u_lane (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_vec (vec_mat),
            .i_row (mat[g]),
            .o_res (res[g]),
            .o_ovf (ovf[g])
        );
    end

    qvr_merge #(.VW(VW)) u_merge (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_res (res),
        .i_ovf (ovf),
        .o_rot (rot),
        .o_ovf (rot_ovf)
    );

    assign o_rot.valid    = r_vld[NSTAGE-1];
    assign o_rot.rot_x    = rot[0];
    assign o_rot.rot_y    = rot[1];
    assign o_rot.rot_z    = rot[2];
    assign o_rot.overflow = rot_ovf;

endmodule

// ===== hdl/qvr_matrix.sv =====
// Quaternion products and rotation matrix, two pipeline stages.
// Carries the input vector alongside; depends on qvr_pkg.
module qvr_matrix #(
    parameter int VW = 16,
    parameter int QF = 14,
    parameter int MW = 34
) (
    input  logic                  i_clk,
    input  qvr_pkg::t_pipe_ctl    i_ctl,
    input  qvr_pkg::t_quat        i_quat,
    input  logic signed [VW-1:0]  i_vec [3],
    output logic signed [VW-1:0]  o_vec [3],
    output logic signed [MW-1:0]  o_mat [3][3]
);
    import qvr_pkg::*;

    localparam logic signed [MW-1:0] ONE = MW'(1) << (2 * QF);

    logic signed [2*QW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [VW-1:0]   r_vec1 [3];
    logic signed [VW-1:0]   r_vec2 [3];
    logic signed [MW-1:0]   r_mat  [3][3];
    logic signed [MW-1:0]   n_mat  [3][3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_xx   <= i_quat.x * i_quat.x;
            r_yy   <= i_quat.y * i_quat.y;
            r_zz   <= i_quat.z * i_quat.z;
            r_xy   <= i_quat.x * i_quat.y;
            r_xz   <= i_quat.x * i_quat.z;
            r_yz   <= i_quat.y * i_quat.z;
            r_wx   <= i_quat.w * i_quat.x;
            r_wy   <= i_quat.w * i_quat.y;
            r_wz   <= i_quat.w * i_quat.z;
            r_vec1 <= i_vec;
        end
    end

    always_comb begin
        n_mat[0][0] = ONE - ((MW'(r_yy) + MW'(r_zz)) <<< 1);
        n_mat[0][1] = (MW'(r_xy) - MW'(r_wz)) <<< 1;
        n_mat[0][2] = (MW'(r_xz) + MW'(r_wy)) <<< 1;
        n_mat[1][0] = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        n_mat[1][1] = ONE - ((MW'(r_xx) + MW'(r_zz)) <<< 1);
        n_mat[1][2] = (MW'(r_yz) - MW'(r_wx)) <<< 1;
        n_mat[2][0] = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        n_mat[2][1] = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        n_mat[2][2] = ONE - ((MW'(r_xx) + MW'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mat_en) begin
            r_mat  <= n_mat;
            r_vec2 <= r_vec1;
        end
    end

    assign o_vec = r_vec2;
    assign o_mat = r_mat;

endmodule

// ===== hdl/qvr_lane.sv =====
// One output component: row-by-vector products, sum with rounding, saturation.
// Two pipeline stages; depends on qvr_pkg.
module qvr_lane #(
    parameter int VW = 16,
    parameter int QF = 14,
    parameter int MW = 34
) (
    input  logic                  i_clk,
    input  qvr_pkg::t_pipe_ctl    i_ctl,
    input  logic signed [VW-1:0]  i_vec [3],
    input  logic signed [MW-1:0]  i_row [3],
    output logic signed [VW-1:0]  o_res,
    output logic                  o_ovf
);
    import qvr_pkg::*;

    localparam int PW = VW + MW;
    localparam int SW = PW + 2;
    localparam int SH = 2 * QF;
    localparam int RW = SW - SH;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (SH - 1);

    logic signed [PW-1:0] r_prod [3];
    logic signed [SW-1:0] r_acc;
    logic signed [SW-1:0] n_acc;
    logic        [RW-1:0] quo;
    logic        [RW-VW:0] top_bits;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= PW'(i_vec[c]) * PW'(i_row[c]);
            end
        end
    end

    assign n_acc = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign quo      = r_acc[SW-1:SH];
    assign top_bits = quo[RW-1:VW-1];
    assign o_ovf    = !((&top_bits) || !(|top_bits));

    always_comb begin
        if (!o_ovf) begin
            o_res = quo[VW-1:0];
        end else if (quo[RW-1]) begin
            o_res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(VW-1){1'b1}}};
        end
    end

endmodule

// ===== hdl/qvr_merge.sv =====
// Output register: collects the three lane results and combines their overflow flags.
// Depends on qvr_pkg.
module qvr_merge #(
    parameter int VW = 16
) (
    input  logic                  i_clk,
    input  qvr_pkg::t_pipe_ctl    i_ctl,
    input  logic signed [VW-1:0]  i_res [3],
    input  logic [2:0]            i_ovf,
    output logic signed [VW-1:0]  o_rot [3],
    output logic                  o_ovf
);
    import qvr_pkg::*;

    logic signed [VW-1:0] r_rot [3];
    logic                 r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            r_rot <= i_res;
            r_ovf <= |i_ovf;
        end
    end

    assign o_rot = r_rot;
    assign o_ovf = r_ovf;

endmodule

// ===== hdl/qvr_checker.sv =====
// Port-level checks for the quaternion vector rotator, bound to the top level.
// Depends on quaternion_vector_rotator_core and its channel interfaces.
module qvr_checker #(
    parameter int VW = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic signed [VW-1:0] i_rot_x,
    input logic signed [VW-1:0] i_rot_y,
    input logic signed [VW-1:0] i_rot_z,
    input logic                 i_overflow
);
    localparam logic [VW-1:0] SAT_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_LO = {1'b1, {(VW-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rot_x)
            && $stable(i_rot_y) && $stable(i_rot_z) && $stable(i_overflow))
        else $error("stalled result changed before transfer");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output register empty");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |->
            i_rot_x == SAT_HI || i_rot_x == SAT_LO || i_rot_y == SAT_HI
            || i_rot_y == SAT_LO || i_rot_z == SAT_HI || i_rot_z == SAT_LO)
        else $error("overflow flagged without a saturated component");

endmodule

bind quaternion_vector_rotator_core qvr_checker #(.VW(VECTOR_WIDTH)) u_qvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_rot_x     (o_rot.rot_x),
    .i_rot_y     (o_rot.rot_y),
    .i_rot_z     (o_rot.rot_z),
    .i_overflow  (o_rot.overflow)
);

// ===== test/testbench.sv =====
// Testbench for quaternion_vector_rotator_core: directed table, then random phases.
// Each result transfer is checked against a typed table entry or an in-bench rotation predictor.
// Depends on qvr_pkg, qvr_vec_if, qvr_rot_if and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam int QFRAC = 14;
    localparam int NPHASE = 13;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 60;
    localparam longint VMAX_L = 32767;
    localparam longint VMIN_L = -32768;

    localparam logic signed [15:0] VMX = 16'sh7fff;
    localparam logic signed [15:0] VMN = 16'sh8000;
    localparam logic signed [15:0] QONE = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ovf;
    } t_rotated;

    typedef struct {
        t_quat              q;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        bit                 typed;
        t_rotated           want;
    } t_dir_row;

    localparam t_quat Q_ID    = '{QONE, 16'sd0, 16'sd0, 16'sd0};
    localparam t_quat Q_XFLIP = '{16'sd0, QONE, 16'sd0, 16'sd0};
    localparam t_quat Q_ZFLIP = '{16'sd0, 16'sd0, 16'sd0, QONE};
    localparam t_quat Q_XHALF = '{16'sd0, 16'sd8192, 16'sd0, 16'sd0};
    localparam t_quat Q_Z90   = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
    localparam t_quat Q_MIN   = '{VMN, VMN, VMN, VMN};
    localparam t_quat Q_MAX   = '{VMX, VMX, VMX, VMX};

    localparam int NDIR = 18;
    t_dir_row dir_tab [NDIR] = '{
        '{Q_ID, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{Q_ID, VMX, VMN, 16'sd1, 1'b1, '{VMX, VMN, 16'sd1, 1'b0}},
        '{Q_ID, VMN, VMX, -16'sd1, 1'b1, '{VMN, VMX, -16'sd1, 1'b0}},
        '{Q_ID, -16'sd1, -16'sd1, -16'sd1, 1'b1, '{-16'sd1, -16'sd1, -16'sd1, 1'b0}},
        '{Q_XFLIP, 16'sd100, 16'sd200, 16'sd300, 1'b1,
          '{16'sd100, -16'sd200, -16'sd300, 1'b0}},
        '{Q_XFLIP, VMN, VMN, 16'sd5, 1'b1, '{VMN, VMX, -16'sd5, 1'b1}},
        '{Q_ZFLIP, 16'sd7, -16'sd9, 16'sd11, 1'b1, '{-16'sd7, 16'sd9, 16'sd11, 1'b0}},
        '{Q_ZFLIP, VMN, VMN, VMN, 1'b1, '{VMX, VMX, VMN, 1'b1}},
        '{Q_XHALF, 16'sd3, 16'sd3, -16'sd3, 1'b1, '{16'sd3, 16'sd2, -16'sd1, 1'b0}},
        '{Q_XHALF, 16'sd1, -16'sd1, 16'sd0, 1'b1, '{16'sd1, 16'sd0, 16'sd0, 1'b0}},
        '{Q_XHALF, VMN, VMX, VMX, 1'b1, '{VMN, 16'sd16384, 16'sd16384, 1'b0}},
        '{Q_Z90, 16'sd1000, 16'sd2000, -16'sd3000, 1'b0, '0},
        '{Q_Z90, VMX, VMX, VMX, 1'b0, '0},
        '{Q_MIN, VMX, VMX, VMX, 1'b0, '0},
        '{Q_MIN, VMN, 16'sd0, VMX, 1'b0, '0},
        '{Q_MIN, 16'sd1, 16'sd0, 16'sd0, 1'b0, '0},
        '{Q_MAX, VMX, VMN, 16'sd12345, 1'b0, '0},
        '{Q_MAX, 16'sd0, 16'sd1, -16'sd1, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    qvr_vec_if #(.W(16)) vec_ch ();
    qvr_rot_if #(.W(16)) rot_ch ();

    quaternion_vector_rotator_core #(
        .VECTOR_WIDTH  (16),
        .QUAT_FRAC_BITS(QFRAC)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_vec     (vec_ch),
        .o_rot     (rot_ch)
    );

    t_rotated rotated_q [$];
    t_quat    cur_quat = Q_ID;
    int       errors = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    int       stall_left = 0;
    bit       hold_go = 1'b0;
    bit       hold_off = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_rotated rotate_vec(t_quat q, logic signed [15:0] vx,
                                            logic signed [15:0] vy,
                                            logic signed [15:0] vz);
        longint w, x, y, z, one, half, acc, r;
        longint mat [3][3];
        longint v [3];
        logic signed [15:0] comp [3];
        bit sat;
        t_rotated res;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        one = longint'(1) <<< (2 * QFRAC);
        half = longint'(1) <<< (2 * QFRAC - 1);
        mat[0][0] = one - 2 * (y * y + z * z);
        mat[0][1] = 2 * (x * y - w * z);
        mat[0][2] = 2 * (x * z + w * y);
        mat[1][0] = 2 * (x * y + w * z);
        mat[1][1] = one - 2 * (x * x + z * z);
        mat[1][2] = 2 * (y * z - w * x);
        mat[2][0] = 2 * (x * z - w * y);
        mat[2][1] = 2 * (y * z + w * x);
        mat[2][2] = one - 2 * (x * x + y * y);
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = half;
            for (int j = 0; j < 3; j++) acc += v[j] * mat[i][j];
            r = acc >>> (2 * QFRAC);
            if (r > VMAX_L) begin
                r = VMAX_L;
                sat = 1'b1;
            end else if (r < VMIN_L) begin
                r = VMIN_L;
                sat = 1'b1;
            end
            comp[i] = r[15:0];
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.ovf = sat;
        return res;
    endfunction

    function automatic logic signed [15:0] edge_value();
        case ($urandom_range(5))
            0: return VMN;
            1: return VMX;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return QONE;
            default: return -QONE;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            1: return 16'($urandom_range(2000)) - 16'sd1000;
            2: return edge_value();
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_quat rand_quat(int mode);
        t_quat q;
        case (mode)
            1: begin
                q.w = 16'($urandom_range(16384)) - 16'sd8192;
                q.x = 16'($urandom_range(16384)) - 16'sd8192;
                q.y = 16'($urandom_range(16384)) - 16'sd8192;
                q.z = 16'($urandom_range(16384)) - 16'sd8192;
            end
            2: q = '{edge_value(), edge_value(), edge_value(), edge_value()};
            3: begin
                q = '0;
                case ($urandom_range(3))
                    0: q.w = $urandom_range(1) ? QONE : -QONE;
                    1: q.x = $urandom_range(1) ? QONE : -QONE;
                    2: q.y = $urandom_range(1) ? QONE : -QONE;
                    default: q.z = $urandom_range(1) ? QONE : -QONE;
                endcase
            end
            default: q = t_quat'({$urandom, $urandom});
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_quat(input t_quat q);
        write_reg(REG_QUAT_W, q.w);
        write_reg(REG_QUAT_X, q.x);
        write_reg(REG_QUAT_Y, q.y);
        write_reg(REG_QUAT_Z, q.z);
        cfg_we <= 1'b0;
        cur_quat = q;
    endtask

    task automatic wait_drained();
        vec_ch.valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_vec(input logic signed [15:0] vx, input logic signed [15:0] vy,
                            input logic signed [15:0] vz, input bit typed,
                            input t_rotated want);
        if ($urandom_range(99) < src_idle_pct) begin
            vec_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= vx;
        vec_ch.vec_y <= vy;
        vec_ch.vec_z <= vz;
        do @(posedge i_clk); while (!vec_ch.ready);
        rotated_q.push_back(typed ? want : rotate_vec(cur_quat, vx, vy, vz));
    endtask

    // hold off the receiver so the pipeline fills and stalls the sender
    initial begin
        wait (hold_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_rotated want;
        if (i_rst_n && rot_ch.valid && rot_ch.ready) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unrequested rot_x", rot_ch.rot_x, 0);
            end else begin
                want = rotated_q.pop_front();
                if (rot_ch.rot_x !== want.x) report_mismatch("rot_x", rot_ch.rot_x, want.x);
                if (rot_ch.rot_y !== want.y) report_mismatch("rot_y", rot_ch.rot_y, want.y);
                if (rot_ch.rot_z !== want.z) report_mismatch("rot_z", rot_ch.rot_z, want.z);
                if (rot_ch.overflow !== want.ovf)
                    report_mismatch("overflow", rot_ch.overflow, want.ovf);
            end
        end
        if (!i_rst_n || hold_off) begin
            rot_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rot_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            stall_left = $urandom_range(12);
            rot_ch.ready <= 1'b0;
        end else begin
            rot_ch.ready <= 1'b1;
        end
    end

    initial begin
        t_quat q;
        int vmode;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        vec_ch.valid = 1'b0;
        vec_ch.vec_x = '0;
        vec_ch.vec_y = '0;
        vec_ch.vec_z = '0;
        rot_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 20;
        sink_stall_pct = 20;
        for (int i = 0; i < NDIR; i++) begin
            if (dir_tab[i].q != cur_quat) begin
                wait_drained();
                write_quat(dir_tab[i].q);
            end
            send_vec(dir_tab[i].vx, dir_tab[i].vy, dir_tab[i].vz, dir_tab[i].typed,
                     dir_tab[i].want);
        end

        for (int p = 0; p < NPHASE; p++) begin
            wait_drained();
            q = rand_quat(p % 4);
            write_quat(q);
            src_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 10 : 35;
            sink_stall_pct = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 35 : 15;
            if (p == 2) begin
                src_idle_pct = 0;
                hold_go = 1'b1;
            end
            if (p == NPHASE - 1) begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                vmode = $urandom_range(3);
                send_vec(rand_comp(vmode), rand_comp(vmode), rand_comp(vmode), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (2 * NSTAGE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/qvr_pkg.sv
hdl/qvr_vec_if.sv
hdl/qvr_rot_if.sv
hdl/qvr_matrix.sv
hdl/qvr_lane.sv
hdl/qvr_merge.sv
hdl/quaternion_vector_rotator_core.sv
hdl/qvr_checker.sv
test/testbench.sv
